// ===== hdl/cdsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdsd_pkg;

	// widths of the request and result fields
	localparam int CMD_W     = 2;
	localparam int RND_W     = 16;
	localparam int RANK_W    = 4;
	localparam int SUIT_W    = 2;
	localparam int LEFT_W    = 6;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	// modulo unit: dividend bits consumed per cycle
	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = RND_W / MOD_BITS;

	typedef enum logic [CMD_W-1:0] {
		CMD_REFILL = 2'd0,
		CMD_SWAP   = 2'd1,
		CMD_DEAL   = 2'd2
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/cdsd_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// iterative remainder: several restoring steps per cycle
module cdsd_mod #(
	parameter int DW = 6
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [cdsd_pkg::RND_W-1:0] dividend,
	input  wire logic [DW-1:0]             divisor,
	output logic                           busy,
	output logic [DW-1:0]                  rem
);

	localparam int CNT_W = $clog2(cdsd_pkg::MOD_STEPS);

	logic [cdsd_pkg::RND_W-1:0] dvd_q, dvd_nx;
	logic [DW-1:0]              dsr_q;
	logic [DW-1:0]              rem_q, rem_nx;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;

	always_comb begin
		logic [DW:0] t;
		t      = '0;
		rem_nx = rem_q;
		dvd_nx = dvd_q;
		for (int k = 0; k < cdsd_pkg::MOD_BITS; k++) begin
			t      = {rem_nx, dvd_nx[cdsd_pkg::RND_W-1]};
			dvd_nx = {dvd_nx[cdsd_pkg::RND_W-2:0], 1'b0};
			if (t >= {1'b0, dsr_q}) begin
				rem_nx = DW'(t - {1'b0, dsr_q});
			end else begin
				rem_nx = t[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(cdsd_pkg::MOD_STEPS - 1);
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== hdl/cdsd_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// card code memory, two read ports, one write port, per-entry valid bits
// an entry never written since reset or refill reads as its own index
module cdsd_store #(
	parameter int DEPTH = 52,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clr,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr_a,
	input  wire logic [AW-1:0] rd_addr_b,
	input  wire logic          we,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [AW-1:0] wr_data,
	output logic [AW-1:0]      rd_data_a,
	output logic [AW-1:0]      rd_data_b
);

	logic [AW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [AW-1:0]    mem_a_s1, mem_b_s1;
	logic [AW-1:0]    addr_a_s1, addr_b_s1;
	logic             vld_a_s1, vld_b_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_a_s1 <= mem[rd_addr_a];
			mem_b_s1 <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_a_s1  <= 1'b0;
			vld_b_s1  <= 1'b0;
			addr_a_s1 <= '0;
			addr_b_s1 <= '0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_s1  <= vld_q[rd_addr_a];
				vld_b_s1  <= vld_q[rd_addr_b];
				addr_a_s1 <= rd_addr_a;
				addr_b_s1 <= rd_addr_b;
			end
		end
	end

	assign rd_data_a = vld_a_s1 ? mem_a_s1 : addr_a_s1;
	assign rd_data_b = vld_b_s1 ? mem_b_s1 : addr_b_s1;

endmodule

`default_nettype wire

// ===== hdl/card_deck_shuffle_deal.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake                     request contents
// s_axis   in   s_axis_tvalid/s_axis_tready   cmd, random_word
// m_axis   out  m_axis_tvalid/m_axis_tready   card_rank, card_suit, cards_left,
//                                             card_valid (tuser), pass_done (tlast)
//
// one request at a time, one result per request
// refill, unused command, empty deal, degenerate swap: result set pending straight from idle
// deal: registered memory read in ST_DREAD, then suit and rank decoded in ST_DEAL
// swap: ST_MOD waits on the modulo unit (4 dividend bits a cycle over 16 bits), then ST_READ,
//   ST_SWAP1 and ST_SWAP2 for the single write port (two writes per swap)
// reset leaves the ordered deck at once through per-entry valid bits, no clearing pass
// a result not taken holds in the output register; a finished result waits behind it and blocks new requests
module card_deck_shuffle_deal #(
	parameter int SUIT_COUNT = 4,
	parameter int RANK_LIMIT = 14
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [1:0] cmd, [17:2] random_word, [23:18] zero
	input  wire logic [cdsd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [3:0] card_rank, [5:4] card_suit, [11:6] cards_left, [15:12] zero
	output logic [cdsd_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	// [0] card_valid
	output logic                                 m_axis_tuser,
	// pass_done
	output logic                                 m_axis_tlast
);

	localparam int RANKS_PER_SUIT = RANK_LIMIT - 1;
	localparam int DECK_SIZE      = SUIT_COUNT * RANKS_PER_SUIT;
	localparam int AW             = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
	localparam int CW             = $clog2(DECK_SIZE + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MOD   = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_SWAP1 = 7'b0001000,
		ST_SWAP2 = 7'b0010000,
		ST_DREAD = 7'b0100000,
		ST_DEAL  = 7'b1000000
	} state_t;

	state_t                         state_q;
	logic                           done_pend_q;
	logic [CW-1:0]                  count_q;
	logic [AW-1:0]                  cursor_q;
	logic [AW-1:0]                  i_q;
	logic                           res_valid_q;
	logic [cdsd_pkg::RANK_W-1:0]    res_rank_q;
	logic [cdsd_pkg::SUIT_W-1:0]    res_suit_q;
	logic                           res_done_q;
	logic                           m_tvalid_q;
	logic [cdsd_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                           m_tuser_q;
	logic                           m_tlast_q;

	logic                           accept;
	cdsd_pkg::cmd_t                 cmd;
	logic [cdsd_pkg::RND_W-1:0]     rnd;
	logic [AW-1:0]                  reload_cur;
	logic [AW-1:0]                  i_clamp;
	logic                           out_free;

	logic                           mod_start;
	logic                           mod_busy;
	logic [CW-1:0]                  mod_rem;

	logic                           st_clr;
	logic                           st_rd_en;
	logic [AW-1:0]                  st_rd_addr_a, st_rd_addr_b;
	logic                           st_we;
	logic [AW-1:0]                  st_wr_addr, st_wr_data;
	logic [AW-1:0]                  st_rd_data_a, st_rd_data_b;

	logic [2:0]                     deal_suit;
	logic [cdsd_pkg::RANK_W-1:0]    deal_rank;
	logic [31:0]                    left_ext;

	// request side: one request is taken only when idle and no result pending
	assign s_axis_tready = (state_q == ST_IDLE) && !done_pend_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cmd           = cdsd_pkg::cmd_t'(s_axis_tdata[cdsd_pkg::CMD_W-1:0]);
	assign rnd           = s_axis_tdata[cdsd_pkg::CMD_W +: cdsd_pkg::RND_W];
	assign out_free      = !m_tvalid_q || m_axis_tready;

	// cursor reload point for the present count
	assign reload_cur = (count_q != '0) ? AW'(count_q - CW'(1)) : '0;

	// cursor clamped into the deck before a swap
	assign i_clamp = (CW'(cursor_q) >= count_q) ? AW'(count_q - CW'(1)) : cursor_q;

	assign mod_start = accept && (cmd == cdsd_pkg::CMD_SWAP) && (count_q > CW'(1))
		&& (i_clamp != '0);

	// memory port control
	assign st_clr       = accept && (cmd == cdsd_pkg::CMD_REFILL);
	assign st_rd_en     = (state_q == ST_READ) || (state_q == ST_DREAD);
	assign st_rd_addr_a = (state_q == ST_READ) ? i_q : AW'(count_q);
	assign st_rd_addr_b = AW'(mod_rem);
	assign st_we        = (state_q == ST_SWAP1) || (state_q == ST_SWAP2);
	assign st_wr_addr   = (state_q == ST_SWAP1) ? i_q : AW'(mod_rem);
	assign st_wr_data   = (state_q == ST_SWAP1) ? st_rd_data_b : st_rd_data_a;

	// code to suit and rank: compare against each suit boundary
	always_comb begin
		logic [31:0] rank_ext;
		deal_suit = '0;
		for (int k = 1; k < SUIT_COUNT; k++) begin
			if (32'(st_rd_data_a) >= 32'(k * RANKS_PER_SUIT)) begin
				deal_suit = 3'(k);
			end
		end
		rank_ext  = 32'(st_rd_data_a) - 32'(deal_suit) * 32'(RANKS_PER_SUIT) + 32'd1;
		deal_rank = rank_ext[cdsd_pkg::RANK_W-1:0];
	end

	assign left_ext = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_pend_q <= 1'b0;
			count_q     <= CW'(DECK_SIZE);
			cursor_q    <= AW'(DECK_SIZE - 1);
			i_q         <= '0;
			res_valid_q <= 1'b0;
			res_rank_q  <= '0;
			res_suit_q  <= '0;
			res_done_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= 1'b0;
			m_tlast_q   <= 1'b0;
		end else begin
			// finished request moves into the output register
			if (done_pend_q && out_free) begin
				done_pend_q <= 1'b0;
				m_tvalid_q  <= 1'b1;
				m_tuser_q   <= res_valid_q;
				m_tlast_q   <= res_done_q;
				m_tdata_q   <= cdsd_pkg::M_TDATA_W'({left_ext[cdsd_pkg::LEFT_W-1:0],
					res_suit_q, res_rank_q});
			end else if (m_tvalid_q && m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_valid_q <= 1'b0;
						res_rank_q  <= '0;
						res_suit_q  <= '0;
						res_done_q  <= 1'b0;
						case (cmd)
							cdsd_pkg::CMD_REFILL: begin
								count_q     <= CW'(DECK_SIZE);
								cursor_q    <= AW'(DECK_SIZE - 1);
								done_pend_q <= 1'b1;
							end
							cdsd_pkg::CMD_SWAP: begin
								if (mod_start) begin
									i_q     <= i_clamp;
									state_q <= ST_MOD;
								end else begin
									// one card or fewer, or cursor already at the bottom
									cursor_q    <= reload_cur;
									res_done_q  <= 1'b1;
									done_pend_q <= 1'b1;
								end
							end
							cdsd_pkg::CMD_DEAL: begin
								if (count_q != '0) begin
									count_q <= count_q - CW'(1);
									state_q <= ST_DREAD;
								end else begin
									done_pend_q <= 1'b1;
								end
							end
							default: begin
								done_pend_q <= 1'b1;
							end
						endcase
					end
				end
				ST_MOD: begin
					if (!mod_busy) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SWAP1;
				end
				ST_SWAP1: begin
					state_q <= ST_SWAP2;
				end
				ST_SWAP2: begin
					if (i_q == AW'(1)) begin
						cursor_q   <= reload_cur;
						res_done_q <= 1'b1;
					end else begin
						cursor_q <= i_q - AW'(1);
					end
					done_pend_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_DREAD: begin
					state_q <= ST_DEAL;
				end
				ST_DEAL: begin
					res_valid_q <= 1'b1;
					res_rank_q  <= deal_rank;
					res_suit_q  <= deal_suit[cdsd_pkg::SUIT_W-1:0];
					cursor_q    <= reload_cur;
					done_pend_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign m_axis_tlast  = m_tlast_q;

	// remainder of the random word by cursor plus one
	cdsd_mod #(
		.DW(CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (rnd),
		.divisor  (CW'(i_clamp) + CW'(1)),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	// deck memory
	cdsd_store #(
		.DEPTH(DECK_SIZE),
		.AW   (AW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (st_clr),
		.rd_en     (st_rd_en),
		.rd_addr_a (st_rd_addr_a),
		.rd_addr_b (st_rd_addr_b),
		.we        (st_we),
		.wr_addr   (st_wr_addr),
		.wr_data   (st_wr_data),
		.rd_data_a (st_rd_data_a),
		.rd_data_b (st_rd_data_b)
	);

`ifndef SYNTH
	// count never grows past a full deck
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DECK_SIZE))
		else $error("card count beyond deck size");

	// at rest the cursor lies inside the deck, or at zero when empty
	a_cursor_in_deck: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((count_q == '0 && cursor_q == '0)
		|| (CW'(cursor_q) < count_q)))
		else $error("pass cursor outside deck");

	// the swap reads only once the remainder is settled
	a_mod_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !mod_busy)
		else $error("swap read with modulo still running");

	// a new result appears only from a finished request
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(done_pend_q))
		else $error("result without finished request");

	// writes stay within the swap and never meet a read or a refill
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (!st_clr && !st_rd_en))
		else $error("memory write overlaps read or refill");
`endif

endmodule

`default_nettype wire
